### hw/rtl/rvrf_pkg.sv
// Shared types and constants for the raster video register file.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rvrf_pkg;

   localparam int ADDR_W        = 6;
   localparam int DATA_W        = 8;
   localparam int LINE_W        = 9;
   localparam int LPF_W         = 10;
   // one bit wider than the address, so the register count itself fits
   localparam int CNT_W         = ADDR_W + 1;
   localparam int REG_COUNT_DEF = 47;

   localparam logic [LPF_W-1:0] LPF_RESET = 10'd312;

   // item operation codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // register map
   localparam logic [ADDR_W-1:0] ADDR_CTRL_HI   = 6'h11;
   localparam logic [ADDR_W-1:0] ADDR_RASTER_LO = 6'h12;
   localparam logic [ADDR_W-1:0] ADDR_CTRL2     = 6'h16;
   localparam logic [ADDR_W-1:0] ADDR_MEMPTR    = 6'h18;
   localparam logic [ADDR_W-1:0] ADDR_STATUS    = 6'h19;
   localparam logic [ADDR_W-1:0] ADDR_ENABLE    = 6'h1A;
   localparam logic [ADDR_W-1:0] ADDR_COLOR_LO  = 6'h20;
   localparam logic [ADDR_W-1:0] ADDR_COLOR_HI  = 6'h2E;

   localparam logic [DATA_W-1:0] SRC_MASK      = 8'h0F;
   localparam logic [DATA_W-1:0] CTRL2_ONES    = 8'hC0;
   localparam logic [DATA_W-1:0] MEMPTR_ONES   = 8'h01;
   localparam logic [DATA_W-1:0] STATUS_ONES   = 8'h70;
   localparam logic [DATA_W-1:0] NIBBLE_ONES   = 8'hF0;
   localparam logic [DATA_W-1:0] RASTER_HIT    = 8'h01;
   localparam logic [DATA_W-1:0] RASTER_CLEAR  = 8'hFE;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } rvrf_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq;
      logic [LINE_W-1:0] current_line;
   } rvrf_result_type;

endpackage

`default_nettype wire

### hw/rtl/rvrf_store.sv
// Byte register store: single-port memory with registered read and
// per-entry valid flops so that unwritten entries read as zero.
// Depends on rvrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvrf_store import rvrf_pkg::*; #(
   parameter int REG_COUNT = REG_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              access,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic      [DATA_W-1:0] rd_data
);

   localparam int IDX_W = $clog2(REG_COUNT);

   logic [DATA_W-1:0]    mem [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [DATA_W-1:0]    rd_data_ff;
   logic                 rd_ok_ff;
   logic                 rd_ok_in;
   logic                 in_range;
   logic [IDX_W-1:0]     idx;
   logic [DATA_W-1:0]    wr_value;
   logic                 do_write;

   assign in_range = {1'b0, addr} < CNT_W'(REG_COUNT);
   assign idx      = addr[IDX_W-1:0];
   assign do_write = access && wr_en && in_range;
   assign rd_ok_in = in_range && vld_ff[idx];
   // enable register keeps only its four source bits
   assign wr_value = (addr == ADDR_ENABLE) ? (wr_data & SRC_MASK) : wr_data;

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[idx] <= wr_value;
      end
      if (access) begin
         rd_data_ff <= mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (do_write) begin
            vld_ff[idx] <= 1'b1;
         end
         if (access) begin
            rd_ok_ff <= rd_ok_in;
         end
      end
   end

   assign rd_data = rd_ok_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

### hw/rtl/rvrf_ctrl.sv
// Raster state and result logic: line counter, raster compare, interrupt
// status/enable and the read merge. Depends on rvrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvrf_ctrl import rvrf_pkg::*; #(
   parameter int REG_COUNT = REG_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire rvrf_item_type     item,
   input  wire logic [DATA_W-1:0] stored,
   input  wire logic [LPF_W-1:0]  lines_per_frame,
   output rvrf_result_type        result
);

   logic [LINE_W-1:0] compare_ff, compare_in;
   logic [DATA_W-1:0] status_ff, status_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic              irq_ff, irq_in;
   logic [3:0]        enable_ff, enable_in;

   logic              in_range;
   logic [LPF_W-1:0]  line_inc;
   logic [LINE_W-1:0] line_tick;
   logic [DATA_W-1:0] status_ack;
   logic [DATA_W-1:0] status_tick;
   logic [DATA_W-1:0] read_val;

   // recompute the summary bit from sources and enable
   function automatic logic [DATA_W-1:0] fold_irq(input logic [DATA_W-1:0] s,
                                                  input logic [3:0] en);
      logic pend;
      pend     = |(s[3:0] & en);
      fold_irq = {pend, s[6:0]};
   endfunction

   assign in_range    = {1'b0, item.addr} < CNT_W'(REG_COUNT);
   assign line_inc    = {1'b0, line_ff} + LPF_W'(1);
   assign line_tick   = (line_inc == lines_per_frame || line_inc[LPF_W-1])
                        ? '0 : line_inc[LINE_W-1:0];
   assign status_ack  = status_ff & ~item.data & SRC_MASK;
   assign status_tick = (line_tick == compare_ff) ? (status_ff | RASTER_HIT)
                                                  : (status_ff & RASTER_CLEAR);

   always_comb begin
      read_val = stored;
      unique case (item.addr)
         ADDR_CTRL_HI:   read_val = {line_ff[LINE_W-1], stored[6:0]};
         ADDR_RASTER_LO: read_val = line_ff[DATA_W-1:0];
         ADDR_CTRL2:     read_val = stored | CTRL2_ONES;
         ADDR_MEMPTR:    read_val = stored | MEMPTR_ONES;
         ADDR_STATUS:    read_val = status_ff | STATUS_ONES;
         ADDR_ENABLE:    read_val = stored | NIBBLE_ONES;
         default: begin
            if (item.addr >= ADDR_COLOR_LO && item.addr <= ADDR_COLOR_HI) begin
               read_val = stored | NIBBLE_ONES;
            end
         end
      endcase
   end

   always_comb begin
      compare_in = compare_ff;
      status_in  = status_ff;
      line_in    = line_ff;
      irq_in     = irq_ff;
      enable_in  = enable_ff;
      result.read_data = '0;
      unique case (item.op)
         OP_READ: result.read_data = read_val;
         OP_WRITE: begin
            if (in_range) begin
               unique case (item.addr)
                  ADDR_CTRL_HI:   compare_in = {item.data[7], compare_ff[7:0]};
                  ADDR_RASTER_LO: compare_in = {compare_ff[LINE_W-1], item.data};
                  ADDR_STATUS: begin
                     status_in = fold_irq(status_ack, enable_ff);
                     irq_in    = status_in[7];
                  end
                  ADDR_ENABLE:    enable_in = item.data[3:0];
                  default: ;
               endcase
            end
         end
         OP_TICK: begin
            line_in   = line_tick;
            status_in = fold_irq(status_tick, enable_ff);
            irq_in    = status_in[7];
         end
         default: ;
      endcase
      result.irq          = irq_in;
      result.current_line = line_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_ff <= '0;
         status_ff  <= '0;
         line_ff    <= '0;
         irq_ff     <= 1'b0;
         enable_ff  <= '0;
      end else if (advance) begin
         compare_ff <= compare_in;
         status_ff  <= status_in;
         line_ff    <= line_in;
         irq_ff     <= irq_in;
         enable_ff  <= enable_in;
      end
   end

`ifndef SYNTHESIS
   a_irq_matches_summary: assert property (@(posedge clock) disable iff (reset)
      irq_ff == status_ff[7])
      else $error("irq line disagrees with status summary bit");

   a_status_unused_zero: assert property (@(posedge clock) disable iff (reset)
      status_ff[6:4] == 3'b000)
      else $error("unused status bits set");

   a_line_moves_on_tick_only: assert property (@(posedge clock) disable iff (reset)
      (advance && item.op != OP_TICK) |=> line_ff == $past(line_ff))
      else $error("raster line changed without a tick");

   a_tick_sets_compare_bit: assert property (@(posedge clock) disable iff (reset)
      (advance && item.op == OP_TICK) |=> status_ff[0] == (line_ff == compare_ff))
      else $error("raster compare bit wrong after tick");
`endif

endmodule

`default_nettype wire

### hw/rtl/raster_video_register_file_core.sv
// Raster video controller register file: bus reads/writes and line ticks
// in, one result word out per item. Depends on rvrf_pkg, rvrf_store, rvrf_ctrl.
// Throughput is one word per clock while rsp_stall is low. There are two
// register stages: the input stage with the registered store read, then
// the state/result logic into the output register that drives rsp_*.
// The byte registers live in a single-port memory whose per-entry valid
// flops are cleared by reset, so no clearing pass is needed and the block
// takes words right after reset. lines_per_frame is written through
// csr_wr_en/csr_wr_data and should only change while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module raster_video_register_file_core import rvrf_pkg::*; #(
   parameter int REG_COUNT = REG_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_op,
   input  wire logic [ADDR_W-1:0] req_addr,
   input  wire logic [DATA_W-1:0] req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [DATA_W-1:0] rsp_read_data,
   output logic                   rsp_irq,
   output logic      [LINE_W-1:0] rsp_current_line,
   input  wire logic              csr_wr_en,
   input  wire logic [LPF_W-1:0]  csr_wr_data
);

   logic            s1_vld_ff, s1_vld_in;
   rvrf_item_type   s1_item_ff;
   logic            out_vld_ff, out_vld_in;
   rvrf_result_type out_res_ff;
   logic [LPF_W-1:0] lpf_ff;

   logic            out_free;
   logic            s1_fire;
   logic            accept;
   logic [DATA_W-1:0] stored;
   rvrf_result_type res;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign s1_fire   = s1_vld_ff && out_free;
   assign req_stall = s1_vld_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_vld_in  = accept || (s1_vld_ff && !s1_fire);
   assign out_vld_in = s1_fire || (out_vld_ff && rsp_stall);

   rvrf_store #(.REG_COUNT(REG_COUNT)) u_store (
      .clock   (clock),
      .reset   (reset),
      .access  (accept),
      .wr_en   (req_op == OP_WRITE),
      .addr    (req_addr),
      .wr_data (req_data),
      .rd_data (stored)
   );

   rvrf_ctrl #(.REG_COUNT(REG_COUNT)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .advance         (s1_fire),
      .item            (s1_item_ff),
      .stored          (stored),
      .lines_per_frame (lpf_ff),
      .result          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         lpf_ff     <= LPF_RESET;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_wr_en) begin
            lpf_ff <= csr_wr_data;
         end
      end
   end

   // hold payloads while their stage is stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= '{op: req_op, addr: req_addr, data: req_data};
      end
      if (s1_fire) begin
         out_res_ff <= res;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_read_data    = out_res_ff.read_data;
   assign rsp_irq          = out_res_ff.irq;
   assign rsp_current_line = out_res_ff.current_line;

endmodule

`default_nettype wire
